/* rtl/agcm_pkg.sv */
// Shared constants, S-box and round functions for the AES-256-GCM encryptor.
// Used by agcm_ghash, aes256_gcm_encrypt and the bench; depends on nothing.
`default_nettype none

package agcm_pkg;

    localparam int LENGTH_BITS_DEF = 36;
    localparam int AES_ROUNDS      = 14;
    localparam int RK_ROWS         = AES_ROUNDS + 1;
    localparam int GH_DIGIT        = 4;
    localparam int GH_STEPS        = 128 / GH_DIGIT;

    localparam logic [7:0]  GF_R       = 8'he1;
    localparam logic [7:0]  XT_POLY    = 8'h1b;
    localparam logic [7:0]  RCON_INIT  = 8'h01;
    localparam logic [31:0] CTR_INIT   = 32'h0000_0001;
    localparam logic [4:0]  FULL_BYTES = 5'd16;

    // item kinds
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;
    localparam logic [1:0] KIND_RSVD   = 2'd3;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? XT_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // SubBytes, ShiftRows and (unless last) MixColumns; byte 0 in the top bits
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [127:0] t;
        logic [127:0] r;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            for (int row = 0; row < 4; row++) begin
                t[127 - 8 * (c * 4 + row) -: 8] =
                    SBOX[s[127 - 8 * (((c + row) & 3) * 4 + row) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[127 - 32 * c -: 8];
            a1 = t[119 - 32 * c -: 8];
            a2 = t[111 - 32 * c -: 8];
            a3 = t[103 - 32 * c -: 8];
            r[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            r[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            r[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            r[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return last ? t : r;
    endfunction

endpackage

`default_nettype wire

/* rtl/agcm_if.sv */
// Valid/ready channel interfaces for input items and result items.
// No dependencies.
`default_nettype none

interface agcm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] iv_head;
    logic [63:0] iv_tail;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    logic [4:0]  block_bytes;

    modport source (output valid, kind, iv_head, iv_tail, block_hi, block_lo, block_bytes,
                    input ready);
    modport sink   (input valid, kind, iv_head, iv_tail, block_hi, block_lo, block_bytes,
                    output ready);
endinterface

interface agcm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_hi;
    logic [63:0] out_lo;
    logic [4:0]  out_bytes;
    logic        is_tag;
    logic        status;

    modport source (output valid, out_hi, out_lo, out_bytes, is_tag, status, input ready);
    modport sink   (input valid, out_hi, out_lo, out_bytes, is_tag, status, output ready);
endinterface

`default_nettype wire

/* rtl/agcm_ghash.sv */
// GF(2^128) multiplier for GHASH, GH_DIGIT bits of the multiplier per cycle.
// Depends on agcm_pkg.
`default_nettype none

module agcm_ghash
    import agcm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [127:0] y,
    input  wire logic [127:0] h,
    output logic [127:0]      z,
    output logic              done
);

    localparam int CW = $clog2(GH_STEPS);

    logic [127:0]  y_reg, v_reg, z_reg;
    logic [127:0]  v_next, z_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;

    // one digit of shift-and-add with reduction
    always_comb
    begin
        z_next = z_reg;
        v_next = v_reg;
        for (int j = 0; j < GH_DIGIT; j++) begin
            if (y_reg[127 - j])
            begin
                z_next = z_next ^ v_next;
            end
            if (v_next[0])
            begin
                v_next = {1'b0, v_next[127:1]} ^ {GF_R, 120'h0};
            end
            else
            begin
                v_next = {1'b0, v_next[127:1]};
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            y_reg <= y;
            v_reg <= h;
            z_reg <= '0;
        end
        else if (busy_reg)
        begin
            y_reg <= y_reg << GH_DIGIT;
            v_reg <= v_next;
            z_reg <= z_next;
        end
    end

    // digit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(GH_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign z    = z_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* rtl/aes256_gcm_encrypt.sv */
// AES-256-GCM encryptor, no AAD. One item at a time, one AES round per cycle.
// Start: key expansion, then two encryptions (hash key and tag mask); no result.
// Data: the next counter block is encrypted with round keys from the round-key memory,
// then GHASH runs at 4 bits a cycle. Finish: GHASH of the length block. Errors skip both.
// Asynchronous active-low reset: idle, no message open, key registers zero.
// Depends on agcm_pkg, agcm_if, agcm_ghash.
`default_nettype none

module aes256_gcm_encrypt
    import agcm_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    agcm_in_if.sink          data_in,
    agcm_out_if.source       data_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_KEXP  = 3'd1;
    localparam logic [2:0] S_ELOAD = 3'd2;
    localparam logic [2:0] S_ENC   = 3'd3;
    localparam logic [2:0] S_GH    = 3'd4;
    localparam logic [2:0] S_RES   = 3'd5;

    localparam logic [1:0] J_HKEY = 2'd0;
    localparam logic [1:0] J_CTR0 = 2'd1;
    localparam logic [1:0] J_DATA = 2'd2;
    localparam logic [1:0] J_FIN  = 2'd3;

    localparam logic [3:0] LAST_RND = 4'(AES_ROUNDS);

    // key registers
    logic [63:0] key_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            key_reg[paddr[4:3]] <= pwdata;
        end
    end

    assign prdata = key_reg[paddr[4:3]];
    assign pready = 1'b1;

    // state and datapath registers
    logic [2:0]             state_reg, state_next;
    logic [1:0]             job_reg, job_next;
    logic [3:0]             rnd_reg, rnd_next;
    logic [7:0]             rc_reg, rc_next;
    logic [255:0]           win_reg, win_next;
    logic [127:0]           aes_in_reg, aes_in_next;
    logic [127:0]           s_reg, s_next;
    logic [127:0]           pt_reg, pt_next;
    logic [4:0]             nb_reg, nb_next;
    logic [127:0]           ctr_reg, ctr_next;
    logic [127:0]           hkey_reg, hkey_next;
    logic [127:0]           mask0_reg, mask0_next;
    logic [127:0]           acc_reg, acc_next;
    logic [127:0]           cipher_reg, cipher_next;
    logic [LENGTH_BITS-1:0] total_reg, total_next;
    logic                   in_msg_reg, in_msg_next;
    logic                   partial_reg, partial_next;
    logic [127:0]           res_data_reg, res_data_next;
    logic [4:0]             res_bytes_reg, res_bytes_next;
    logic                   res_tag_reg, res_tag_next;
    logic                   res_status_reg, res_status_next;
    logic [127:0]           out_data_reg;
    logic [4:0]             out_bytes_reg;
    logic                   out_tag_reg, out_status_reg, out_valid_reg;
    logic                   out_load;

    // round-key memory: one 128-bit row per round key, RK_ROWS rows
    logic [127:0] rk_mem [RK_ROWS];
    logic [127:0] rk_q, rk_wdata;
    logic [3:0]   rk_raddr;
    logic         rk_we;

    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[rnd_reg] <= rk_wdata;
        end
        rk_q <= rk_mem[rk_raddr];
    end

    // writes happen only during key expansion; the read address advances only while encrypting, else row 0
    assign rk_we    = (state_reg == S_KEXP);
    assign rk_raddr = (state_reg == S_ENC && rnd_reg != LAST_RND) ? 4'(rnd_reg + 4'd1) : 4'd0;

    // key schedule: four words a cycle from the last eight
    logic [31:0] w7, kx_f, n0, n1, n2, n3;

    always_comb
    begin
        w7   = win_reg[31:0];
        kx_f = rnd_reg[0] ? subst_word(w7)
                          : subst_word({w7[23:0], w7[31:24]}) ^ {rc_reg, 24'h0};
        n0   = win_reg[255:224] ^ kx_f;
        n1   = win_reg[223:192] ^ n0;
        n2   = win_reg[191:160] ^ n1;
        n3   = win_reg[159:128] ^ n2;
        case (rnd_reg)
            4'd0:    rk_wdata = {key_reg[0], key_reg[1]};
            4'd1:    rk_wdata = {key_reg[2], key_reg[3]};
            default: rk_wdata = {n0, n1, n2, n3};
        endcase
    end

    // AES round output and ciphertext
    logic [127:0] enc_out, byte_mask, data_ct, gh_y, gh_z;
    logic         gh_start, gh_done;

    assign enc_out = aes_round(s_reg, rnd_reg == LAST_RND) ^ rk_q;
    assign data_ct = (pt_reg ^ enc_out) & byte_mask;

    always_comb
    begin
        for (int k = 0; k < 16; k++) begin
            byte_mask[127 - 8 * k -: 8] = (5'(k) < nb_reg) ? 8'hff : 8'h00;
        end
    end

    // input checks
    logic [4:0]           n_eff;
    logic [LENGTH_BITS:0] total_sum;
    logic                 data_err;
    logic [63:0]          len_bits;

    assign n_eff     = (data_in.block_bytes > FULL_BYTES) ? FULL_BYTES : data_in.block_bytes;
    assign total_sum = {1'b0, total_reg} + (LENGTH_BITS + 1)'(n_eff);
    assign data_err  = !in_msg_reg || partial_reg || (n_eff == 5'd0) || total_sum[LENGTH_BITS];
    assign len_bits  = 64'(total_reg) << 3;

    assign data_in.ready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        rnd_next        = rnd_reg;
        rc_next         = rc_reg;
        win_next        = win_reg;
        aes_in_next     = aes_in_reg;
        s_next          = s_reg;
        pt_next         = pt_reg;
        nb_next         = nb_reg;
        ctr_next        = ctr_reg;
        hkey_next       = hkey_reg;
        mask0_next      = mask0_reg;
        acc_next        = acc_reg;
        cipher_next     = cipher_reg;
        total_next      = total_reg;
        in_msg_next     = in_msg_reg;
        partial_next    = partial_reg;
        res_data_next   = res_data_reg;
        res_bytes_next  = res_bytes_reg;
        res_tag_next    = res_tag_reg;
        res_status_next = res_status_reg;
        gh_start        = 1'b0;
        gh_y            = acc_reg ^ data_ct;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (data_in.valid)
                begin
                    res_data_next   = '0;
                    res_bytes_next  = '0;
                    res_tag_next    = 1'b0;
                    res_status_next = 1'b1;
                    case (data_in.kind)
                        KIND_START:
                        begin
                            ctr_next   = {data_in.iv_head, data_in.iv_tail, CTR_INIT};
                            rnd_next   = '0;
                            rc_next    = RCON_INIT;
                            state_next = S_KEXP;
                        end
                        KIND_DATA:
                        begin
                            if (data_err)
                            begin
                                state_next = S_RES;
                            end
                            else
                            begin
                                ctr_next    = {ctr_reg[127:32], ctr_reg[31:0] + 32'd1};
                                aes_in_next = {ctr_reg[127:32], ctr_reg[31:0] + 32'd1};
                                pt_next     = {data_in.block_hi, data_in.block_lo};
                                nb_next     = n_eff;
                                job_next    = J_DATA;
                                state_next  = S_ELOAD;
                            end
                        end
                        KIND_FINISH:
                        begin
                            if (!in_msg_reg)
                            begin
                                state_next = S_RES;
                            end
                            else
                            begin
                                gh_y       = acc_reg ^ {64'h0, len_bits};
                                gh_start   = 1'b1;
                                job_next   = J_FIN;
                                state_next = S_GH;
                            end
                        end
                        default: state_next = S_RES;
                    endcase
                end
            end
            S_KEXP:
            begin
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == 4'd0)
                begin
                    win_next = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
                end
                else if (rnd_reg != 4'd1)
                begin
                    win_next = {win_reg[127:0], n0, n1, n2, n3};
                    if (!rnd_reg[0])
                    begin
                        rc_next = xtime(rc_reg);
                    end
                end
                if (rnd_reg == LAST_RND)
                begin
                    aes_in_next = '0;
                    job_next    = J_HKEY;
                    state_next  = S_ELOAD;
                end
            end
            S_ELOAD:
            begin
                rnd_next   = '0;
                state_next = S_ENC;
            end
            S_ENC:
            begin
                rnd_next = rnd_reg + 4'd1;
                s_next   = (rnd_reg == 4'd0) ? (aes_in_reg ^ rk_q) : enc_out;
                if (rnd_reg == LAST_RND)
                begin
                    case (job_reg)
                        J_HKEY:
                        begin
                            hkey_next   = enc_out;
                            aes_in_next = ctr_reg;
                            job_next    = J_CTR0;
                            state_next  = S_ELOAD;
                        end
                        J_CTR0:
                        begin
                            mask0_next   = enc_out;
                            acc_next     = '0;
                            total_next   = '0;
                            in_msg_next  = 1'b1;
                            partial_next = 1'b0;
                            state_next   = S_IDLE;
                        end
                        default:
                        begin
                            cipher_next = data_ct;
                            gh_start    = 1'b1;
                            state_next  = S_GH;
                        end
                    endcase
                end
            end
            S_GH:
            begin
                if (gh_done)
                begin
                    acc_next        = gh_z;
                    res_status_next = 1'b0;
                    state_next      = S_RES;
                    if (job_reg == J_DATA)
                    begin
                        total_next     = total_reg + LENGTH_BITS'(nb_reg);
                        partial_next   = partial_reg || (nb_reg != FULL_BYTES);
                        res_data_next  = cipher_reg;
                        res_bytes_next = nb_reg;
                        res_tag_next   = 1'b0;
                    end
                    else
                    begin
                        in_msg_next    = 1'b0;
                        res_data_next  = gh_z ^ mask0_reg;
                        res_bytes_next = FULL_BYTES;
                        res_tag_next   = 1'b1;
                    end
                end
            end
            S_RES:
            begin
                if (!out_valid_reg || data_out.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= J_HKEY;
            in_msg_reg    <= 1'b0;
            partial_reg   <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            job_reg     <= job_next;
            in_msg_reg  <= in_msg_next;
            partial_reg <= partial_next;
            total_reg   <= total_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (data_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rnd_reg        <= rnd_next;
        rc_reg         <= rc_next;
        win_reg        <= win_next;
        aes_in_reg     <= aes_in_next;
        s_reg          <= s_next;
        pt_reg         <= pt_next;
        nb_reg         <= nb_next;
        ctr_reg        <= ctr_next;
        hkey_reg       <= hkey_next;
        mask0_reg      <= mask0_next;
        acc_reg        <= acc_next;
        cipher_reg     <= cipher_next;
        res_data_reg   <= res_data_next;
        res_bytes_reg  <= res_bytes_next;
        res_tag_reg    <= res_tag_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_data_reg   <= res_data_reg;
            out_bytes_reg  <= res_bytes_reg;
            out_tag_reg    <= res_tag_reg;
            out_status_reg <= res_status_reg;
        end
    end

    agcm_ghash u_ghash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gh_start),
        .y     (gh_y),
        .h     (hkey_reg),
        .z     (gh_z),
        .done  (gh_done)
    );

    assign data_out.valid     = out_valid_reg;
    assign data_out.out_hi    = out_data_reg[127:64];
    assign data_out.out_lo    = out_data_reg[63:0];
    assign data_out.out_bytes = out_bytes_reg;
    assign data_out.is_tag    = out_tag_reg;
    assign data_out.status    = out_status_reg;

    // checks
    a_gh_done_in_gh: assert property (@(posedge clk) disable iff (!rst_n)
        gh_done |-> state_reg == S_GH)
        else $error("GHASH finished outside its wait state");

    a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ENC || state_reg == S_KEXP) |-> rnd_reg <= LAST_RND)
        else $error("round counter beyond last round");

    a_tag_full: assert property (@(posedge clk) disable iff (!rst_n)
        (data_out.valid && data_out.is_tag) |-> (data_out.out_bytes == FULL_BYTES
                                                 && !data_out.status))
        else $error("tag item malformed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (data_out.valid && data_out.status) |-> (data_out.out_hi == 64'h0
            && data_out.out_lo == 64'h0 && data_out.out_bytes == 5'd0 && !data_out.is_tag))
        else $error("error item carries payload");

    a_start_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> data_out.valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for aes256_gcm_encrypt: a cycle-free predictor of AES-256-GCM
// checks every result item. Depends on agcm_pkg, agcm_if and the encryptor RTL.
`timescale 1ns / 1ps

module tb_top
    import agcm_pkg::*;
;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] iv_head;
        logic [63:0] iv_tail;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
        logic [4:0]  block_bytes;
    } gcm_item_t;

    typedef struct packed {
        logic [63:0] out_hi;
        logic [63:0] out_lo;
        logic [4:0]  out_bytes;
        logic        is_tag;
        logic        status;
    } gcm_result_t;

    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  DRAIN_WAIT  = 80;
    localparam int  PHASE_ITEMS = 330;
    localparam logic [63:0] BYTE_LIMIT = (64'd1 << LENGTH_BITS_DEF) - 64'd1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    agcm_in_if  in_ch ();
    agcm_out_if out_ch ();

    aes256_gcm_encrypt DUT (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .data_in(in_ch), .data_out(out_ch)
    );

    always #6 clk = ~clk;

    // predictor state
    logic [63:0]  key_copy [4];
    logic [31:0]  sched [60];
    logic [127:0] hkey = '0, ctr_blk = '0, tag_mask = '0, hash_acc = '0;
    logic [LENGTH_BITS_DEF-1:0] msg_bytes = '0;
    logic         msg_open = 1'b0, short_seen = 1'b0;

    gcm_item_t   pending_items [$];
    gcm_result_t expected_results [$];
    gcm_item_t   on_wire;
    int fail_count = 0, cycles = 0, results_seen = 0;
    int n_start = 0, n_data = 0, n_tag = 0, n_err = 0;
    int send_gap = 0, recv_stall = 0;
    bit long_hold_done = 0, burst_mode = 0;

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    task automatic build_schedule();
        logic [7:0]  rc;
        logic [31:0] t;
        rc = 8'h01;
        for (int i = 0; i < 4; i++) begin
            sched[2 * i]     = key_copy[i][63:32];
            sched[2 * i + 1] = key_copy[i][31:0];
        end
        for (int i = 8; i < 60; i++) begin
            t = sched[i - 1];
            if ((i % 8) == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = dbl(rc);
            end
            else if ((i % 8) == 4)
                t = sbox_word(t);
            sched[i] = sched[i - 8] ^ t;
        end
    endtask

    // byte k of a block lives at [127-8k -: 8]
    function automatic logic [127:0] cipher(input logic [127:0] blk);
        logic [127:0] s, t;
        logic [7:0]   a0, a1, a2, a3;
        s = blk;
        for (int r = 0; r <= 14; r++) begin
            s = s ^ {sched[4 * r], sched[4 * r + 1], sched[4 * r + 2], sched[4 * r + 3]};
            if (r == 14)
                break;
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    t[127 - 8 * (c * 4 + row) -: 8] =
                        SBOX[s[127 - 8 * (((c + row) % 4) * 4 + row) -: 8]];
            if (r < 13) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[127 - 32 * c -: 8];
                    a1 = t[119 - 32 * c -: 8];
                    a2 = t[111 - 32 * c -: 8];
                    a3 = t[103 - 32 * c -: 8];
                    s[127 - 32 * c -: 8] = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
                    s[119 - 32 * c -: 8] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
                    s[111 - 32 * c -: 8] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
                    s[103 - 32 * c -: 8] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
                end
            end
            else
                s = t;
        end
        return s;
    endfunction

    // GF(2^128) product, GCM bit order
    function automatic logic [127:0] gf_mult(input logic [127:0] x, input logic [127:0] h);
        logic [127:0] z, v;
        logic         lsb;
        z = '0;
        v = h;
        for (int i = 0; i < 128; i++) begin
            if (x[127 - i])
                z = z ^ v;
            lsb = v[0];
            v = v >> 1;
            if (lsb)
                v[127:120] = v[127:120] ^ 8'he1;
        end
        return z;
    endfunction

    task automatic push_error();
        expected_results.push_back('{64'h0, 64'h0, 5'd0, 1'b0, 1'b1});
        n_err++;
    endtask

    // work out the result of one accepted item
    task automatic predict_item(input gcm_item_t it);
        logic [63:0]  n;
        logic [127:0] ct, tg;
        case (it.kind)
            KIND_START: begin
                build_schedule();
                hkey = cipher('0);
                ctr_blk = {it.iv_head, it.iv_tail, 32'h1};
                tag_mask = cipher(ctr_blk);
                hash_acc = '0;
                msg_bytes = '0;
                msg_open = 1'b1;
                short_seen = 1'b0;
                n_start++;
            end
            KIND_DATA: begin
                n = 64'(it.block_bytes);
                if (!msg_open || short_seen || n == 0)
                    push_error();
                else begin
                    if (n > 16)
                        n = 16;
                    if (64'(msg_bytes) > BYTE_LIMIT - n)
                        push_error();
                    else begin
                        ctr_blk[31:0] = ctr_blk[31:0] + 32'd1;
                        ct = ({it.block_hi, it.block_lo} ^ cipher(ctr_blk))
                             & ({128{1'b1}} << (8 * (16 - n)));
                        hash_acc = gf_mult(hash_acc ^ ct, hkey);
                        msg_bytes = msg_bytes + LENGTH_BITS_DEF'(n);
                        if (n < 16)
                            short_seen = 1'b1;
                        expected_results.push_back('{ct[127:64], ct[63:0], 5'(n), 1'b0, 1'b0});
                        n_data++;
                    end
                end
            end
            KIND_FINISH: begin
                if (!msg_open)
                    push_error();
                else begin
                    hash_acc = gf_mult(hash_acc ^ {64'h0, 64'(msg_bytes) << 3}, hkey);
                    msg_open = 1'b0;
                    tg = hash_acc ^ tag_mask;
                    expected_results.push_back('{tg[127:64], tg[63:0], FULL_BYTES, 1'b1, 1'b0});
                    n_tag++;
                end
            end
            default: push_error();
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    function automatic gcm_item_t mk(input logic [1:0] k, input logic [31:0] ivh,
                                     input logic [63:0] ivt, input logic [63:0] hi,
                                     input logic [63:0] lo, input logic [4:0] nb);
        return '{k, ivh, ivt, hi, lo, nb};
    endfunction

    function automatic gcm_item_t rnd_item(input logic [1:0] k, input logic [4:0] nb);
        return mk(k, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, nb);
    endfunction

    // cycle count, timeout, and toggling of idle-free stretches
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles % 300 == 0)
            burst_mode <= ($urandom_range(0, 3) == 0);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // input driver
    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            predict_item(on_wire);
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.kind        <= KIND_START;
            in_ch.iv_head     <= '0;
            in_ch.iv_tail     <= '0;
            in_ch.block_hi    <= '0;
            in_ch.block_lo    <= '0;
            in_ch.block_bytes <= '0;
        end
        else if (in_ch.valid && !in_ch.ready)
            ;   // hold the offered item
        else if (send_gap > 0)
        begin
            send_gap = send_gap - 1;
            in_ch.valid <= 1'b0;
        end
        else if (pending_items.size() > 0)
        begin
            on_wire = pending_items.pop_front();
            in_ch.kind        <= on_wire.kind;
            in_ch.iv_head     <= on_wire.iv_head;
            in_ch.iv_tail     <= on_wire.iv_tail;
            in_ch.block_hi    <= on_wire.block_hi;
            in_ch.block_lo    <= on_wire.block_lo;
            in_ch.block_bytes <= on_wire.block_bytes;
            in_ch.valid <= 1'b1;
            send_gap = pick_gap();
        end
        else
            in_ch.valid <= 1'b0;
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        gcm_result_t e;
        if (out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result item: hi %h lo %h", out_ch.out_hi, out_ch.out_lo);
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (out_ch.out_hi !== e.out_hi)
                begin
                    $error("out_hi expected %h actual %h", e.out_hi, out_ch.out_hi);
                    fail_count++;
                end
                if (out_ch.out_lo !== e.out_lo)
                begin
                    $error("out_lo expected %h actual %h", e.out_lo, out_ch.out_lo);
                    fail_count++;
                end
                if (out_ch.out_bytes !== e.out_bytes)
                begin
                    $error("out_bytes expected %0d actual %0d", e.out_bytes, out_ch.out_bytes);
                    fail_count++;
                end
                if (out_ch.is_tag !== e.is_tag)
                begin
                    $error("is_tag expected %b actual %b", e.is_tag, out_ch.is_tag);
                    fail_count++;
                end
                if (out_ch.status !== e.status)
                begin
                    $error("status expected %b actual %b", e.status, out_ch.status);
                    fail_count++;
                end
            end
        end
        // one long hold-off so the block backs up onto its input
        if (!long_hold_done && results_seen >= 150)
        begin
            long_hold_done = 1;
            recv_stall = 900;
        end
        if (recv_stall > 0)
        begin
            recv_stall--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            recv_stall = pick_gap();
        end
    end

    task automatic reg_write(input int idx, input logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(8 * idx);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        key_copy[idx] = val;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // one well-formed message, or now and then a broken sequence
    task automatic queue_message();
        int nblk;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            case ($urandom_range(0, 4))
                0: pending_items.push_back(rnd_item(KIND_DATA, 5'($urandom_range(1, 31))));
                1: pending_items.push_back(rnd_item(KIND_FINISH, 5'($urandom)));
                2: pending_items.push_back(rnd_item(KIND_RSVD, 5'($urandom)));
                3: pending_items.push_back(rnd_item(KIND_DATA, 5'd0));
                default: pending_items.push_back(rnd_item(KIND_START, 5'($urandom)));
            endcase
            return;
        end
        pending_items.push_back(rnd_item(KIND_START, 5'($urandom)));
        nblk = $urandom_range(0, 6);
        for (int i = 0; i < nblk; i++)
        begin
            if (i == nblk - 1 && $urandom_range(0, 2) == 0)
                pending_items.push_back(rnd_item(KIND_DATA, 5'($urandom_range(1, 15))));
            else if ($urandom_range(0, 9) == 0)
                pending_items.push_back(rnd_item(KIND_DATA, 5'($urandom_range(16, 31))));
            else
                pending_items.push_back(rnd_item(KIND_DATA, FULL_BYTES));
        end
        if (pick < 14)
            pending_items.push_back(rnd_item(KIND_DATA, 5'($urandom_range(0, 31))));
        if (pick < 18)
            return;   // abandoned, next start restarts
        pending_items.push_back(rnd_item(KIND_FINISH, 5'($urandom)));
        if (pick < 22)
            pending_items.push_back(rnd_item(KIND_FINISH, 5'($urandom)));
    endtask

    task automatic run_phase(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3);
        int queued;
        int prev_size;
        reg_write(0, k0);
        reg_write(1, k1);
        reg_write(2, k2);
        reg_write(3, k3);
        queued = 0;
        while (queued < PHASE_ITEMS)
        begin
            prev_size = pending_items.size();
            queue_message();
            queued = queued + (pending_items.size() - prev_size);
            while (pending_items.size() > 8)
                @(posedge clk);
        end
        drain();
    endtask

    initial
    begin
        gcm_item_t full_ones;
        for (int i = 0; i < 4; i++)
            key_copy[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with a random key
        reg_write(0, {$urandom, $urandom});
        reg_write(1, {$urandom, $urandom});
        reg_write(2, {$urandom, $urandom});
        reg_write(3, {$urandom, $urandom});
        full_ones = '1;
        pending_items.push_back(rnd_item(KIND_FINISH, FULL_BYTES));    // finish, no message
        pending_items.push_back(rnd_item(KIND_DATA, FULL_BYTES));      // data, no message
        pending_items.push_back(rnd_item(KIND_RSVD, FULL_BYTES));      // unused kind
        pending_items.push_back(mk(KIND_START, '0, '0, '0, '0, '0));
        pending_items.push_back(mk(KIND_FINISH, '0, '0, '0, '0, '0));  // empty message
        pending_items.push_back(mk(KIND_START, '1, '1, '1, '1, '1));
        pending_items.push_back(mk(KIND_DATA, '0, '0, '1, '1, FULL_BYTES));
        pending_items.push_back(mk(KIND_DATA, '1, '1, '0, '0, FULL_BYTES));
        pending_items.push_back(rnd_item(KIND_DATA, 5'd0));            // zero byte count
        pending_items.push_back(rnd_item(KIND_DATA, 5'd31));           // oversized count
        pending_items.push_back(rnd_item(KIND_DATA, 5'd17));
        pending_items.push_back(rnd_item(KIND_DATA, 5'd1));            // partial block
        pending_items.push_back(rnd_item(KIND_DATA, FULL_BYTES));      // data after partial
        pending_items.push_back(full_ones);                            // kind 3, all ones
        pending_items.push_back(rnd_item(KIND_FINISH, 5'd0));
        pending_items.push_back(rnd_item(KIND_FINISH, 5'd0));          // finish twice
        pending_items.push_back(rnd_item(KIND_START, 5'd0));
        pending_items.push_back(rnd_item(KIND_DATA, 5'd5));
        pending_items.push_back(rnd_item(KIND_START, 5'd0));           // restart mid-message
        pending_items.push_back(rnd_item(KIND_DATA, FULL_BYTES));
        pending_items.push_back(rnd_item(KIND_DATA, 5'd15));
        pending_items.push_back(rnd_item(KIND_FINISH, 5'd0));
        drain();   // sender waits for every result

        run_phase({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
        run_phase('0, '0, '0, '0);
        run_phase('1, '1, '1, '1);
        run_phase({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});

        $display("Covered %0d starts, %0d data blocks, %0d tags, %0d error results",
                 n_start, n_data, n_tag, n_err);
        $display("over five key settings including all-zero and all-one keys");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/agcm_pkg.sv
rtl/agcm_if.sv
rtl/agcm_ghash.sv
rtl/aes256_gcm_encrypt.sv
bench/tb_top.sv
